[design/bsud_pkg.sv]
`timescale 1ns / 1ps
// bsud_pkg: button codes, stage codes, state and result types and the step-button table
// shared by every file of the button sequence unlock detector; no dependencies
package bsud_pkg;

  localparam int unsigned BtnW   = 16;
  localparam int unsigned StageW = 4;

  typedef logic [BtnW-1:0]   btn_t;
  typedef logic [StageW-1:0] stage_t;

  // held-button bit positions
  localparam btn_t BTN_DLEFT  = 16'h0001;
  localparam btn_t BTN_DRIGHT = 16'h0002;
  localparam btn_t BTN_DDOWN  = 16'h0004;
  localparam btn_t BTN_DUP    = 16'h0008;
  localparam btn_t BTN_Z      = 16'h0010;
  localparam btn_t BTN_R      = 16'h0020;
  localparam btn_t BTN_L      = 16'h0040;
  localparam btn_t BTN_A      = 16'h0080;
  localparam btn_t BTN_B      = 16'h0100;
  localparam btn_t BTN_START  = 16'h0200;
  localparam btn_t BTN_CLEFT  = 16'h0400;
  localparam btn_t BTN_CRIGHT = 16'h0800;
  localparam btn_t BTN_CDOWN  = 16'h1000;
  localparam btn_t BTN_CUP    = 16'h2000;
  localparam btn_t BTN_NONE   = 16'h0000;

  // progress codes
  localparam stage_t STAGE_START  = 4'd0;
  localparam stage_t STAGE_FIRST  = 4'd1;
  localparam stage_t STAGE_STEP2  = 4'd2;
  localparam stage_t STAGE_STEP3  = 4'd3;
  localparam stage_t STAGE_STEP4  = 4'd4;
  localparam stage_t STAGE_STEP5  = 4'd5;
  localparam stage_t STAGE_STEP6  = 4'd6;
  localparam stage_t STAGE_STEP7  = 4'd7;
  localparam stage_t STAGE_STEP8  = 4'd8;
  localparam stage_t STAGE_STEP9  = 4'd9;
  localparam stage_t STAGE_A_SEEN = 4'd10;
  localparam stage_t STAGE_B_SEEN = 4'd11;
  localparam stage_t STAGE_BOTH   = 4'd12;
  localparam stage_t STAGE_DONE   = 4'd13;

  // sequence state held between samples
  typedef struct packed {
    btn_t   prev_buttons;
    stage_t stage;
    logic   release_pending;
    logic   unlock_flag;
  } seq_state_t;

  // one result item
  typedef struct packed {
    logic   enabled;
    stage_t stage;
    logic   must_release;
  } result_t;

  // button that advances from stage s-1 to stage s, for s = 2..9
  function automatic btn_t step_button(input stage_t s);
    btn_t b;
    unique case (s)
      STAGE_STEP2: b = BTN_DUP;
      STAGE_STEP3: b = BTN_CDOWN;
      STAGE_STEP4: b = BTN_CUP;
      STAGE_STEP5: b = BTN_DDOWN;
      STAGE_STEP6: b = BTN_DLEFT;
      STAGE_STEP7: b = BTN_CLEFT;
      STAGE_STEP8: b = BTN_CRIGHT;
      default:     b = BTN_DRIGHT;
    endcase
    return b;
  endfunction

endpackage

[design/bsud_if.sv]
`timescale 1ns / 1ps
// bsud_sample_if / bsud_result_if: valid-ready channels for samples and results
// depends on bsud_pkg
interface bsud_sample_if;
  logic               valid;
  logic               ready;
  bsud_pkg::btn_t     buttons;

  modport source (output valid, output buttons, input ready);
  modport sink   (input valid, input buttons, output ready);
endinterface

interface bsud_result_if;
  logic               valid;
  logic               ready;
  logic               enabled;
  bsud_pkg::stage_t   stage;
  logic               must_release;

  modport source (output valid, output enabled, output stage, output must_release,
                  input ready);
  modport sink   (input valid, input enabled, input stage, input must_release,
                  output ready);
endinterface

[design/bsud_step.sv]
`timescale 1ns / 1ps
// bsud_step: combinational next-state logic for one button sample
// depends on bsud_pkg
module bsud_step (
  input  bsud_pkg::btn_t     buttons,
  input  bsud_pkg::seq_state_t cur,
  output bsud_pkg::seq_state_t nxt
);
  import bsud_pkg::*;

  btn_t   fresh;
  stage_t st_in;
  stage_t st;
  stage_t st_inc;
  logic   pend;

  assign fresh  = buttons & ~cur.prev_buttons;
  assign st_in  = cur.release_pending ? STAGE_START : cur.stage;
  assign st_inc = st_in + 4'd1;

  always_comb begin
    st   = cur.stage;
    pend = cur.release_pending;
    if (buttons == BTN_NONE && cur.release_pending) begin
      pend = 1'b0;
    end else if (fresh != BTN_NONE) begin
      unique case (st_in) inside
        [STAGE_FIRST:STAGE_STEP8]: begin
          if (fresh == step_button(st_inc)) begin
            st = st_inc;
            if (st_inc[0]) pend = 1'b1;
          end else begin
            st = STAGE_START;
          end
        end
        STAGE_STEP9: begin
          if (fresh == (BTN_A | BTN_B))  st = STAGE_BOTH;
          else if (fresh == BTN_A)       st = STAGE_A_SEEN;
          else if (fresh == BTN_B)       st = STAGE_B_SEEN;
          else                           st = STAGE_START;
        end
        STAGE_A_SEEN: st = (fresh == BTN_B) ? STAGE_BOTH : STAGE_START;
        STAGE_B_SEEN: st = (fresh == BTN_A) ? STAGE_BOTH : STAGE_START;
        STAGE_BOTH:   st = (fresh == BTN_START) ? STAGE_DONE : STAGE_START;
        default: begin
          // start stage and unreachable codes
          st = STAGE_START;
          if (buttons == (BTN_L | BTN_R | BTN_Z) && fresh == BTN_Z) begin
            st   = STAGE_FIRST;
            pend = 1'b1;
          end
        end
      endcase
    end

    nxt.prev_buttons = buttons;
    nxt.unlock_flag  = cur.unlock_flag;
    if (st == STAGE_DONE) begin
      nxt.unlock_flag     = ~cur.unlock_flag;
      nxt.stage           = STAGE_START;
      nxt.release_pending = 1'b0;
    end else begin
      nxt.stage           = st;
      nxt.release_pending = pend;
    end
  end

endmodule

[design/bsud_out_buf.sv]
`timescale 1ns / 1ps
// bsud_out_buf: result register with one skid entry, so a sample can be taken
// while the previous result waits; depends on bsud_pkg
module bsud_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bsud_pkg::result_t push_data,
  output logic              can_push,
  output logic              out_valid,
  input  logic              out_ready,
  output bsud_pkg::result_t out_data
);
  import bsud_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign can_push = ~skid_valid;
  assign pop      = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || pop) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= push;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid)  out_data <= skid_data;
      else if (push)   out_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  // skid entry only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid while output register empty");

  // a stalled result is not overwritten
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // a full buffer takes no sample
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("sample pushed into a full buffer");

endmodule

[design/button_sequence_unlock_detector.sv]
`timescale 1ns / 1ps
// button_sequence_unlock_detector: top level of the unlock sequence detector
// depends on bsud_pkg, bsud_if, bsud_step, bsud_out_buf
//
// usage
//   sample (sink): one 16-bit held-button word per transaction
//   result (source): one transaction per sample with the unlock flag, the
//     sequence stage and the must-release flag after that sample
//   each accepted sample updates the sequence state in the same cycle; its
//   result is registered in the result register, or in the skid entry when the
//   receiver stalls; throughput is one sample per cycle while sample.ready is
//   high, through the step logic into the state and result registers
//   when the receiver stalls, one more sample is taken into a skid entry
//   behind the held result; after that sample.ready drops until the result
//   register drains, and no result is ever dropped or repeated
//   synchronous reset clears the previous-button word, the stage, the
//   must-release flag, the unlock flag and both result entries
module button_sequence_unlock_detector (
  input logic            clk,
  input logic            rst,
  bsud_sample_if.sink    sample,
  bsud_result_if.source  result
);
  import bsud_pkg::*;

  // sequence state registers
  btn_t       prev_buttons;
  stage_t     stage;
  logic       release_pending;
  logic       unlock_flag;

  seq_state_t cur;
  seq_state_t state_next;
  result_t    res_next;
  result_t    res_out;
  logic       in_fire;
  logic       can_push;

  assign cur.prev_buttons    = prev_buttons;
  assign cur.stage           = stage;
  assign cur.release_pending = release_pending;
  assign cur.unlock_flag     = unlock_flag;

  assign sample.ready = can_push;
  assign in_fire      = sample.valid & can_push;

  // next state for the incoming sample
  bsud_step u_step (
    .buttons (sample.buttons),
    .cur     (cur),
    .nxt     (state_next)
  );

  // state moves only on an accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_buttons    <= BTN_NONE;
      stage           <= STAGE_START;
      release_pending <= 1'b0;
      unlock_flag     <= 1'b0;
    end else if (in_fire) begin
      prev_buttons    <= state_next.prev_buttons;
      stage           <= state_next.stage;
      release_pending <= state_next.release_pending;
      unlock_flag     <= state_next.unlock_flag;
    end
  end

  // the result is the state after the sample
  assign res_next.enabled      = state_next.unlock_flag;
  assign res_next.stage        = state_next.stage;
  assign res_next.must_release = state_next.release_pending;

  bsud_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire),
    .push_data (res_next),
    .can_push  (can_push),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (res_out)
  );

  assign result.enabled      = res_out.enabled;
  assign result.stage        = res_out.stage;
  assign result.must_release = res_out.must_release;

  // the stored stage never holds an unused code
  a_stage_range: assert property (@(posedge clk) disable iff (rst)
    stage <= STAGE_BOTH)
    else $error("stage register holds an unused code");

  // the unlock flag only flips on a sample taken at the both-seen stage
  a_flag_toggle: assert property (@(posedge clk) disable iff (rst)
    !(in_fire && stage == STAGE_BOTH && !release_pending) |=> $stable(unlock_flag))
    else $error("unlock flag changed outside completion");

  // no state change without an accepted sample
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> ($stable(stage) && $stable(release_pending) && $stable(prev_buttons)))
    else $error("sequence state changed without a sample");

endmodule

[verif/bsud_checker.sv]
`timescale 1ns / 1ps
// bsud_checker: predicts the lock result of every accepted sample and compares it
// with the result channel; depends on bsud_pkg and the bsud_if channel interfaces
module bsud_checker (
  input  logic        clk,
  input  logic        rst,
  bsud_sample_if      sample,
  bsud_result_if      result,
  output int unsigned errors,
  output int unsigned waiting,
  output int unsigned checked,
  output int unsigned unlocks
);
  import bsud_pkg::*;

  localparam int unsigned ReportMax = 10;

  seq_state_t  lock_state;
  result_t     lock_results_due[$];
  int unsigned err_cnt;
  int unsigned chk_cnt;
  int unsigned unlock_cnt;

  // button that moves the sequence on from stage st (st in 1..8)
  function automatic btn_t key_after(input stage_t st);
    case (st)
      STAGE_FIRST: return BTN_DUP;
      STAGE_STEP2: return BTN_CDOWN;
      STAGE_STEP3: return BTN_CUP;
      STAGE_STEP4: return BTN_DDOWN;
      STAGE_STEP5: return BTN_DLEFT;
      STAGE_STEP6: return BTN_CLEFT;
      STAGE_STEP7: return BTN_CRIGHT;
      default:     return BTN_DRIGHT;
    endcase
  endfunction

  // advance the lock by one sample and return what the block should report
  function automatic result_t step_lock(input btn_t now);
    btn_t   fresh;
    stage_t st;
    logic   pend;
    fresh = now & ~lock_state.prev_buttons;
    st    = lock_state.stage;
    pend  = lock_state.release_pending;
    lock_state.prev_buttons = now;

    if (now == BTN_NONE && pend) begin
      pend = 1'b0;
    end else if (fresh != BTN_NONE) begin
      // a press while a release is owed counts as a fresh start
      if (pend) st = STAGE_START;
      if (st >= STAGE_FIRST && st <= STAGE_STEP8) begin
        if (fresh == key_after(st)) begin
          st = st + 1'b1;
          if (st[0]) pend = 1'b1;
        end else begin
          st = STAGE_START;
        end
      end else if (st == STAGE_STEP9) begin
        if (fresh == (BTN_A | BTN_B)) st = STAGE_BOTH;
        else if (fresh == BTN_A)      st = STAGE_A_SEEN;
        else if (fresh == BTN_B)      st = STAGE_B_SEEN;
        else                          st = STAGE_START;
      end else if (st == STAGE_A_SEEN) begin
        st = (fresh == BTN_B) ? STAGE_BOTH : STAGE_START;
      end else if (st == STAGE_B_SEEN) begin
        st = (fresh == BTN_A) ? STAGE_BOTH : STAGE_START;
      end else if (st == STAGE_BOTH) begin
        st = (fresh == BTN_START) ? STAGE_DONE : STAGE_START;
      end else begin
        st = STAGE_START;
        if (now == (BTN_L | BTN_R | BTN_Z) && fresh == BTN_Z) begin
          st   = STAGE_FIRST;
          pend = 1'b1;
        end
      end
    end

    if (st == STAGE_DONE) begin
      lock_state.unlock_flag = ~lock_state.unlock_flag;
      unlock_cnt++;
      st   = STAGE_START;
      pend = 1'b0;
    end
    lock_state.stage           = st;
    lock_state.release_pending = pend;
    return '{enabled: lock_state.unlock_flag, stage: st, must_release: pend};
  endfunction

  always @(posedge clk) begin
    result_t due;
    result_t seen;
    if (rst) begin
      lock_state = '0;
      lock_results_due.delete();
      err_cnt    = 0;
      chk_cnt    = 0;
      unlock_cnt = 0;
    end else begin
      // results first: the result of a sample taken this edge is not yet registered
      if (result.valid && result.ready) begin
        seen = '{enabled: result.enabled, stage: result.stage,
                 must_release: result.must_release};
        if (lock_results_due.size() == 0) begin
          err_cnt++;
          if (err_cnt <= ReportMax)
            $display("unexpected result transaction: enabled=%0b stage=%0d must_release=%0b",
                     seen.enabled, seen.stage, seen.must_release);
        end else begin
          due = lock_results_due.pop_front();
          chk_cnt++;
          if (seen.enabled !== due.enabled || seen.stage !== due.stage ||
              seen.must_release !== due.must_release) begin
            err_cnt++;
            if (err_cnt <= ReportMax)
              $display("result %0d wrong: expected enabled=%0b stage=%0d must_release=%0b, %s",
                       chk_cnt, due.enabled, due.stage, due.must_release,
                       $sformatf("got enabled=%0b stage=%0d must_release=%0b",
                                 seen.enabled, seen.stage, seen.must_release));
          end
        end
      end
      if (sample.valid && sample.ready) begin
        due = step_lock(sample.buttons);
        lock_results_due.push_back(due);
      end
    end
    errors  <= err_cnt;
    waiting <= lock_results_due.size();
    checked <= chk_cnt;
    unlocks <= unlock_cnt;
  end

endmodule

[verif/button_sequence_unlock_detector_tb.sv]
`timescale 1ns / 1ps
// button_sequence_unlock_detector_tb: stimulus, handshake pacing and verdict for the
// unlock detector; depends on bsud_pkg, bsud_if, the design and bsud_checker
module button_sequence_unlock_detector_tb;
  import bsud_pkg::*;

  localparam int unsigned SampleTarget  = 1150; // stop building stimulus past this
  localparam int unsigned CalmTail      = 150;  // last samples run with no idling
  localparam int unsigned DrainAt       = 700;  // sender waits for all results here
  localparam int unsigned HoldAt        = 300;  // results checked before the long stall
  localparam int unsigned HoldCycles    = 60;
  localparam int unsigned WatchdogLimit = 2000;

  logic        clk;
  logic        rst;
  logic        calm;          // set for the tail of the run: no idling on either side
  btn_t        button_words[$];
  int unsigned errors;
  int unsigned waiting;
  int unsigned checked;
  int unsigned unlocks;
  int unsigned stall_cycles;

  bsud_sample_if sample_ch ();
  bsud_result_if result_ch ();

  button_sequence_unlock_detector u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch)
  );

  bsud_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .result  (result_ch),
    .errors  (errors),
    .waiting (waiting),
    .checked (checked),
    .unlocks (unlocks)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  // owed release: usually all buttons up, now and then the release is skipped so
  // the next press lands while the block still wants a release
  function automatic btn_t let_go(input btn_t held);
    if ($urandom_range(0, 3) == 0) button_words.push_back(held); // no new press
    if ($urandom_range(0, 24) != 0) begin
      repeat ($urandom_range(1, 2)) button_words.push_back(BTN_NONE);
      return BTN_NONE;
    end
    return held;
  endfunction

  // press one more key, keeping or dropping what is held; rarely fumbled
  function automatic btn_t press(input btn_t held, input btn_t key);
    btn_t word;
    word = ($urandom_range(0, 1) ? held : BTN_NONE) | key;
    if ($urandom_range(0, 39) == 0) word = btn_t'($urandom);
    button_words.push_back(word);
    return word;
  endfunction

  // one pass through the whole unlock sequence with random pacing and holding
  function automatic void queue_unlock_attempt();
    btn_t path [8];
    btn_t held;
    int   k;
    path[0] = BTN_DUP;
    path[1] = BTN_CDOWN;
    path[2] = BTN_CUP;
    path[3] = BTN_DDOWN;
    path[4] = BTN_DLEFT;
    path[5] = BTN_CLEFT;
    path[6] = BTN_CRIGHT;
    path[7] = BTN_DRIGHT;
    if ($urandom_range(0, 2) == 0) button_words.push_back(BTN_R);
    button_words.push_back(BTN_L | BTN_R);
    held = press(BTN_L | BTN_R, BTN_Z);
    for (k = 0; k < 8; k++) begin
      // stages 1, 3, 5 and 7 were just entered when k is even
      if (k % 2 == 0) held = let_go(held);
      held = press(held, path[k]);
    end
    held = let_go(held);
    case ($urandom_range(0, 2))
      0: held = press(held, BTN_A | BTN_B);
      1: begin
        held = press(held, BTN_A);
        held = press(held, BTN_B);
      end
      default: begin
        held = press(held, BTN_B);
        held = press(held, BTN_A);
      end
    endcase
    held = press(held, BTN_START);
    held = let_go(held);
  endfunction

  // short bursts of junk: random words, all up, all down, single buttons, the start chord
  function automatic void queue_noise();
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 4))
        0:       button_words.push_back(btn_t'($urandom));
        1:       button_words.push_back(BTN_NONE);
        2:       button_words.push_back(~BTN_NONE);
        3:       button_words.push_back(btn_t'(1) << $urandom_range(0, 15));
        default: button_words.push_back(BTN_L | BTN_R | BTN_Z);
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // sample driver
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned idx;
    bit          lazy;
    sample_ch.valid   <= 1'b0;
    sample_ch.buttons <= BTN_NONE;
    calm              <= 1'b0;

    // directed: one clean unlock, then all buttons, then a press while a release is owed
    button_words.push_back(BTN_L | BTN_R);
    button_words.push_back(BTN_L | BTN_R | BTN_Z);     // stage 1, release owed
    button_words.push_back(BTN_NONE);                  // release clears the flag
    button_words.push_back(BTN_DUP);
    button_words.push_back(BTN_DUP | BTN_CDOWN);       // stage 3 with dup still held
    button_words.push_back(BTN_NONE);
    button_words.push_back(BTN_CUP);
    button_words.push_back(BTN_CUP | BTN_DDOWN);
    button_words.push_back(BTN_NONE);
    button_words.push_back(BTN_DLEFT);
    button_words.push_back(BTN_CLEFT);
    button_words.push_back(BTN_NONE);
    button_words.push_back(BTN_CRIGHT);
    button_words.push_back(BTN_DRIGHT);                // stage 9
    button_words.push_back(BTN_NONE);
    button_words.push_back(BTN_A);
    button_words.push_back(BTN_A);                     // held, nothing new
    button_words.push_back(BTN_A | BTN_B);             // both seen
    button_words.push_back(BTN_START);                 // unlock toggles on
    button_words.push_back(~BTN_NONE);                 // every button at once
    button_words.push_back(BTN_NONE);
    button_words.push_back(BTN_L | BTN_R);
    button_words.push_back(BTN_L | BTN_R | BTN_Z);
    button_words.push_back(BTN_L | BTN_R | BTN_Z | btn_t'(16'h8000)); // press while owed
    button_words.push_back(BTN_NONE);

    // random: mostly well-formed attempts, the rest noise
    while (button_words.size() < SampleTarget) begin
      if ($urandom_range(0, 9) < 8) queue_unlock_attempt();
      else queue_noise();
    end

    lazy = 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);

    for (idx = 0; idx < button_words.size(); idx++) begin
      if (idx == button_words.size() - CalmTail) calm <= 1'b1;
      if ($urandom_range(0, 39) == 0) lazy = !lazy;
      if (idx == DrainAt) begin
        // pause until every outstanding result has been taken
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while (waiting != 0);
      end else if (idx < button_words.size() - CalmTail && lazy &&
                   $urandom_range(0, 7) == 0) begin
        sample_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      sample_ch.valid   <= 1'b1;
      sample_ch.buttons <= button_words[idx];
      do @(posedge clk); while (!sample_ch.ready);
    end
    sample_ch.valid <= 1'b0;

    // drain, then keep the clock running so the result path can show anything stray
    do @(posedge clk); while (waiting != 0);
    repeat (4) @(posedge clk);

    $display("covered %0d samples (%0d unlock toggles); %0d result transactions checked",
             button_words.size(), unlocks, checked);
    if (errors == 0 && waiting == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result receiver: random stall bursts, one long hold to back up the block
  // ---------------------------------------------------------------------------
  initial begin
    bit long_done;
    bit lazy;
    result_ch.ready <= 1'b0;
    long_done = 1'b0;
    lazy      = 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!long_done && checked >= HoldAt) begin
        // sender keeps offering, so the skid entry fills and sample.ready drops
        long_done = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (!calm && lazy && $urandom_range(0, 7) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end
      if ($urandom_range(0, 99) == 0) lazy = !lazy;
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any transaction on either channel ends the run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WatchdogLimit) begin
      $display("watchdog: no transaction for %0d cycles", stall_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
